// File: hdl/plt_pkg.sv
// Package of shared types, constants and envelope functions for the pulsing LED table.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    localparam int MAX_LEDS_DEF = 64;
    localparam int PHASE_STEPS  = 15;
    localparam int RAMP_LAST    = 3;
    localparam int RAMP_UNIT    = 4;
    localparam int FALL_BASE    = 19;
    localparam int SCALE_SHIFT  = 4;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    typedef struct packed {
        logic [3:0] y;
        logic [3:0] x;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic       dropped;
        logic [4:0] num;
        entry_t     entry;
    } res_req_t;

    function automatic logic [3:0] phase_advance(input logic [3:0] p);
        logic [3:0] n;
        if (p == 4'(PHASE_STEPS - 1))
            n = 4'd0;
        else
            n = p + 4'd1;
        return n;
    endfunction

    function automatic logic [4:0] pulse_num(input logic [3:0] p);
        logic [4:0] n;
        if (p <= 4'(RAMP_LAST))
            n = 5'(({1'b0, p} + 5'd1) * 5'(RAMP_UNIT));
        else
            n = 5'(FALL_BASE) - {1'b0, p};
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/plt_cell.sv
// One table cell: holds an entry and takes its neighbour's entry or a loaded one.
`timescale 1ns / 1ps
`default_nettype none

module plt_cell
    import plt_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     load_data,
    input  wire entry_t     right,
    output entry_t          q
);

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            q_reg <= load_data;
        else if (ctrl.shift)
            q_reg <= right;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: hdl/plt_scaler.sv
// Output stage: scales an entry's colour by the envelope and registers the result.
`timescale 1ns / 1ps
`default_nettype none

module plt_scaler
    import plt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire res_req_t req,
    output logic          result_valid,
    output logic [3:0]    out_x,
    output logic [3:0]    out_y,
    output logic [7:0]    out_red,
    output logic [7:0]    out_green,
    output logic [7:0]    out_blue,
    output logic          last_of_run,
    output logic          add_dropped
);

    function automatic logic [7:0] scale(input logic [7:0] b, input logic [4:0] n);
        logic [12:0] prod;
        prod = {5'b0, b} * {8'b0, n};
        return prod[SCALE_SHIFT +: 8];
    endfunction

    logic       valid_reg;
    logic [3:0] x_reg;
    logic [3:0] y_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       last_reg;
    logic       dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= req.entry.x;
        y_reg       <= req.entry.y;
        red_reg     <= scale(req.entry.red, req.num);
        green_reg   <= scale(req.entry.green, req.num);
        blue_reg    <= scale(req.entry.blue, req.num);
        last_reg    <= req.last;
        dropped_reg <= req.dropped;
    end

    assign result_valid = valid_reg;
    assign out_x        = x_reg;
    assign out_y        = y_reg;
    assign out_red      = red_reg;
    assign out_green    = green_reg;
    assign out_blue     = blue_reg;
    assign last_of_run  = last_reg;
    assign add_dropped  = dropped_reg;

endmodule

`default_nettype wire

// File: hdl/pulsing_led_table_top.sv
// Top level of the pulsing LED table: command decode, walk sequencer and cell chain.
//
// An item is taken when start is high and busy is low. Add and clear leave busy
// low, as do a remove on an empty table and a tick while stopped. A remove or a
// running tick on a non-empty table raises busy for a walk: the entries sit
// in a chain of cells that rotates one place a cycle past the head, so every walk
// visits the whole table. A tick emits one result a cycle on result_valid, the
// first passing the walk state and then the scaler's output register; a dropped
// add gives its single result in the cycle straight after the edge that takes it.
// Results cannot be held off and must be taken on the cycle they appear.
`timescale 1ns / 1ps
`default_nettype none

module pulsing_led_table_top
    import plt_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] mode,
    input  wire logic [3:0] led_x,
    input  wire logic [3:0] led_y,
    input  wire logic [7:0] in_red,
    input  wire logic [7:0] in_green,
    input  wire logic [7:0] in_blue,
    output logic            result_valid,
    output logic [3:0]      out_x,
    output logic [3:0]      out_y,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output logic            last_of_run,
    output logic            add_dropped
);

    localparam int CNT_W = $clog2(MAX_LEDS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    localparam logic OP_REMOVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic             op_reg;
    logic             op_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             found_reg;
    logic             found_next;
    logic [3:0]       phase_reg;
    logic [3:0]       phase_next;
    logic             running_reg;
    logic             running_next;
    logic [4:0]       num_reg;
    logic [4:0]       num_next;
    logic [3:0]       key_x_reg;
    logic [3:0]       key_y_reg;

    entry_t           cell_q [MAX_LEDS];
    cell_ctrl_t       cell_ctrl [MAX_LEDS];
    entry_t           head;
    entry_t           in_entry;
    entry_t           load_data;
    res_req_t         req;

    logic             accept;
    logic             full;
    logic             add_ok;
    logic             add_full;
    logic             walk_shift;
    logic             load_tail;
    logic             drop;
    logic [3:0]       tick_phase;

    assign accept   = start && !busy;
    assign busy     = (state_reg == ST_WALK);
    assign full     = (count_reg == CNT_W'(MAX_LEDS));
    assign add_ok   = accept && (mode == MODE_ADD) && !full;
    assign add_full = accept && (mode == MODE_ADD) && full;
    assign head     = cell_q[0];

    assign in_entry.x     = led_x;
    assign in_entry.y     = led_y;
    assign in_entry.red   = in_red;
    assign in_entry.green = in_green;
    assign in_entry.blue  = in_blue;

    assign load_data  = load_tail ? head : in_entry;
    assign tick_phase = phase_advance(phase_reg);

    always_comb
    begin
        walk_shift = 1'b0;
        load_tail  = 1'b0;
        drop       = 1'b0;
        if (state_reg == ST_WALK)
        begin
            walk_shift = 1'b1;
            if (op_reg == OP_REMOVE && !found_reg &&
                head.x == key_x_reg && head.y == key_y_reg)
                drop = 1'b1;
            else
                load_tail = 1'b1;
        end
    end

    for (genvar i = 0; i < MAX_LEDS; i++)
    begin : g_cell
        entry_t right;

        if (i == MAX_LEDS - 1)
        begin : g_end
            assign right = cell_q[i];
        end
        else
        begin : g_mid
            assign right = cell_q[i + 1];
        end

        assign cell_ctrl[i].shift = walk_shift;
        assign cell_ctrl[i].load  = (add_ok && (CNT_W'(i) == count_reg)) ||
                                    (load_tail && (CNT_W'(i) == count_reg - CNT_W'(1)));

        plt_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .load_data (load_data),
            .right     (right),
            .q         (cell_q[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        phase_next   = phase_reg;
        running_next = running_reg;
        num_next     = num_reg;

        if (state_reg == ST_WALK)
        begin
            step_next = step_reg - CNT_W'(1);
            if (drop)
            begin
                found_next = 1'b1;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                    running_next = 1'b0;
            end
            if (step_reg == CNT_W'(1))
                state_next = ST_IDLE;
        end
        else if (accept)
        begin
            case (mode)
                MODE_ADD:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == '0)
                            running_next = 1'b1;
                    end
                end
                MODE_REMOVE:
                begin
                    if (count_reg != '0)
                    begin
                        state_next = ST_WALK;
                        op_next    = OP_REMOVE;
                        step_next  = count_reg;
                        found_next = 1'b0;
                    end
                end
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                MODE_TICK:
                begin
                    if (running_reg)
                    begin
                        phase_next = tick_phase;
                        num_next   = pulse_num(tick_phase);
                        if (count_reg != '0)
                        begin
                            state_next = ST_WALK;
                            op_next    = OP_TICK;
                            step_next  = count_reg;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_REMOVE;
            step_reg    <= '0;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            phase_reg   <= 4'd0;
            running_reg <= 1'b0;
            num_reg     <= 5'd0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            phase_reg   <= phase_next;
            running_reg <= running_next;
            num_reg     <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_x_reg <= led_x;
            key_y_reg <= led_y;
        end
    end

    always_comb
    begin
        req.valid   = add_full || (state_reg == ST_WALK && op_reg == OP_TICK);
        req.dropped = add_full;
        req.last    = (state_reg == ST_WALK) && (op_reg == OP_TICK) &&
                      (step_reg == CNT_W'(1));
        req.num     = num_reg;
        req.entry   = add_full ? '0 : head;
    end

    plt_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .result_valid (result_valid),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .last_of_run  (last_of_run),
        .add_dropped  (add_dropped)
    );

    a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> step_reg != '0 && step_reg <= count_reg)
        else $error("walk step count out of range");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEDS))
        else $error("entry count above table size");

    a_count_running: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> running_reg)
        else $error("entries held while stopped");

    a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode == MODE_TICK && running_reg && count_reg != '0
        |=> state_reg == ST_WALK && op_reg == OP_TICK)
        else $error("running tick did not start a walk");

    a_single_drop: assert property (@(posedge clk) disable iff (!rst_n)
        drop |=> found_reg)
        else $error("removal not recorded");

endmodule

`default_nettype wire
